// ===== src/s256_pkg.sv =====
// s256_pkg: shared types, constants and round functions of the sha-256 byte stream hasher
// used by s256_front, s256_core, s256_back and the top level; no dependencies
package s256_pkg;

	// eight 32-bit hash words, element 0 is word a / digest word 0
	typedef logic [7:0][31:0] hash_t;

	// initial hash values, listed from word 7 down to word 0
	localparam hash_t IV_HASH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam int unsigned QDEPTH   = 4;
	localparam int unsigned QPTR_W   = $clog2(QDEPTH);

	// queue entry between front and back
	typedef struct packed {
		logic       fin;
		logic [7:0] data;
	} q_entry_t;

	// control from back to the compression core
	typedef struct packed {
		logic        word_valid;
		logic        start;
		logic        init;
		logic [31:0] word;
	} core_ctl_t;

	typedef enum logic [1:0] {
		CR_IDLE,
		CR_ROUND,
		CR_UPDATE
	} cr_state_t;

	typedef enum logic [2:0] {
		BK_RUN,
		BK_PAD,
		BK_ZERO,
		BK_LEN,
		BK_WAIT,
		BK_OUT
	} bk_state_t;

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	// round constants
	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k;
		case (t)
			6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

endpackage

// ===== src/s256_front.sv =====
// s256_front: input stream acceptance, item classification and the short item queue
// depends on s256_pkg
module s256_front
	import s256_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tuser,   // [0] operation
	output logic       head_valid,
	output q_entry_t   head,
	input  logic       pop
);

	q_entry_t          q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              do_pop;

	// handshake and queue status
	assign s_axis_tready = (count_q != (QPTR_W+1)'(QDEPTH)) ? 1'b1 : 1'b0;
	assign push          = s_axis_tvalid && s_axis_tready;
	assign head_valid    = (count_q != '0);
	assign head          = q_mem_q[rd_ptr_q];
	assign do_pop        = pop && head_valid;

	// queue storage, classified at entry
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q].fin  <= s_axis_tuser;
			q_mem_q[wr_ptr_q].data <= s_axis_tdata;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

// ===== src/s256_core.sv =====
// s256_core: sha-256 compression, one round per cycle, with the message schedule window
// and the chaining words; depends on s256_pkg
module s256_core
	import s256_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  core_ctl_t ctl,
	output logic      busy,
	output hash_t     chain
);

	cr_state_t   state_q;
	cr_state_t   state_nx;
	logic [31:0] w_q [16];
	hash_t       wv_q;
	hash_t       chain_q;
	logic [5:0]  rnd_q;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] w_new;
	logic [31:0] ch;
	logic [31:0] mj;
	logic        shift_w;

	assign chain = chain_q;

	// round datapath
	always_comb begin
		ch    = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
		mj    = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
		t1    = wv_q[7] + bsig1(wv_q[4]) + ch + round_k(rnd_q) + w_q[0];
		t2    = bsig0(wv_q[0]) + mj;
		w_new = w_q[0] + ssig0(w_q[1]) + w_q[9] + ssig1(w_q[14]);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			CR_IDLE:   if (ctl.start) state_nx = CR_ROUND;
			CR_ROUND:  if (rnd_q == 6'd63) state_nx = CR_UPDATE;
			CR_UPDATE: state_nx = CR_IDLE;
			default:   state_nx = CR_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy    = 1'b1;
		shift_w = 1'b0;
		case (state_q)
			CR_IDLE: begin
				busy    = 1'b0;
				shift_w = ctl.word_valid;
			end
			CR_ROUND:  shift_w = 1'b1;
			CR_UPDATE: busy = 1'b1;
			default:   busy = 1'b1;
		endcase
	end

	// schedule window: loads block words, then produces w[t+16] each round
	always_ff @(posedge clk) begin
		if (shift_w) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= (state_q == CR_ROUND) ? w_new : ctl.word;
		end
	end

	// working variables
	always_ff @(posedge clk) begin
		if (state_q == CR_IDLE && ctl.start) begin
			wv_q <= chain_q;
		end else if (state_q == CR_ROUND) begin
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
	end

	// control state and chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CR_IDLE;
			rnd_q   <= '0;
			chain_q <= IV_HASH;
		end else begin
			state_q <= state_nx;
			if (state_q == CR_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end else begin
				rnd_q <= '0;
			end
			if (state_q == CR_UPDATE) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + wv_q[i];
				end
			end else if (state_q == CR_IDLE && ctl.init) begin
				chain_q <= IV_HASH;
			end
		end
	end

endmodule

// ===== src/s256_back.sv =====
// s256_back: block assembly, padding and length sequencer, and the digest output register
// depends on s256_pkg; drives s256_core through core_ctl_t
module s256_back
	import s256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  q_entry_t    head,
	output logic        pop,
	output core_ctl_t   ctl,
	input  logic        busy,
	input  hash_t       chain,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
	output logic        m_axis_tlast   // last_word
);

	bk_state_t   state_q;
	bk_state_t   state_nx;
	logic [5:0]  fill_q;
	logic [63:0] msg_bits_q;
	logic [23:0] acc_q;
	logic [2:0]  cnt_q;
	logic        out_valid_q;
	logic [31:0] out_word_q;
	logic [2:0]  out_idx_q;
	logic        out_last_q;
	logic        push;
	logic        absorb;
	logic [7:0]  push_byte;
	logic        load;
	logic        restart;
	logic [7:0]  len_byte;

	// big-endian length byte, byte 0 of the field first
	assign len_byte = msg_bits_q[{~cnt_q, 3'b000} +: 8];

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			BK_RUN:  if (head_valid && head.fin && !busy) state_nx = BK_PAD;
			BK_PAD:  if (!busy) state_nx = BK_ZERO;
			BK_ZERO: if (!busy && fill_q == LEN_POS) state_nx = BK_LEN;
			BK_LEN:  if (!busy && cnt_q == 3'd7) state_nx = BK_WAIT;
			BK_WAIT: if (!busy) state_nx = BK_OUT;
			BK_OUT:  if (load && cnt_q == 3'd7) state_nx = BK_RUN;
			default: state_nx = BK_RUN;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pop       = 1'b0;
		push      = 1'b0;
		absorb    = 1'b0;
		push_byte = '0;
		load      = 1'b0;
		restart   = 1'b0;
		case (state_q)
			BK_RUN: begin
				pop       = head_valid && !busy;
				push      = head_valid && !busy && !head.fin;
				absorb    = push;
				push_byte = head.data;
			end
			BK_PAD: begin
				push      = !busy;
				push_byte = PAD_BYTE;
			end
			BK_ZERO: begin
				push = !busy && (fill_q != LEN_POS);
			end
			BK_LEN: begin
				push      = !busy;
				push_byte = len_byte;
			end
			BK_WAIT: begin
				push = 1'b0;
			end
			BK_OUT: begin
				load    = !out_valid_q || m_axis_tready;
				restart = load && (cnt_q == 3'd7);
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// words into the core; the 64th byte starts the compression
	always_comb begin
		ctl.word_valid = push && (fill_q[1:0] == 2'b11);
		ctl.start      = push && (fill_q == 6'd63);
		ctl.init       = restart;
		ctl.word       = {acc_q, push_byte};
	end

	// byte accumulator
	always_ff @(posedge clk) begin
		if (push) begin
			acc_q <= {acc_q[15:0], push_byte};
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_word_q <= chain[cnt_q];
			out_idx_q  <= cnt_q;
			out_last_q <= (cnt_q == 3'd7);
		end
	end

	// control state, counts and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_RUN;
			fill_q      <= '0;
			msg_bits_q  <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (push) begin
				fill_q <= fill_q + 6'd1;
			end
			if (restart) begin
				msg_bits_q <= '0;
			end else if (absorb) begin
				msg_bits_q <= msg_bits_q + 64'd8;
			end
			if ((state_q == BK_LEN && push) || load) begin
				cnt_q <= cnt_q + 3'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_idx_q, out_word_q};
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== src/sha256_byte_stream_hasher_unit.sv =====
// sha256_byte_stream_hasher_unit: top level of the sha-256 byte stream hasher
// depends on s256_pkg, s256_front, s256_core, s256_back
//
// channel   dir  beat fields
// s_axis    in   tdata[7:0] data_byte; tuser operation (0 absorb, 1 finish)
// m_axis    out  tdata[31:0] digest_word, tdata[34:32] word_index; tlast last_word
//
// an absorb beat is taken by the back end only while the core is idle; every 64th byte
// starts a compression of 64 rounds and one chain update, during which no byte is taken
// a finish pushes the pad, zero and length bytes up to the block end, compresses one or
// two blocks, then sends eight output beats
// a four-entry queue takes beats until full while the back end compresses or output stalls
// reset is asynchronous, active low, and leaves the initial hash values loaded
module sha256_byte_stream_hasher_unit
	import s256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
	output logic        m_axis_tlast    // last_word
);

	logic      head_valid;
	q_entry_t  head;
	logic      pop;
	core_ctl_t core_ctl;
	logic      core_busy;
	hash_t     chain;

	// front: accept and queue items
	s256_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop)
	);

	// back: block assembly, padding, digest output
	s256_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.ctl           (core_ctl),
		.busy          (core_busy),
		.chain         (chain),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// compression engine
	s256_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (core_ctl),
		.busy   (core_busy),
		.chain  (chain)
	);

	// no block word is handed to the core while it compresses
	a_no_word_busy: assert property (@(posedge clk) disable iff (!arst_n)
		core_ctl.word_valid |-> !core_busy)
		else $error("block word issued while core busy");

	// compression only ever begins on a start request
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(core_busy) |-> $past(core_ctl.start))
		else $error("core went busy without start");

	// the last digest beat carries word index seven
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[34:32] == 3'd7))
		else $error("last digest beat has wrong index");

	// restoring the initial values only happens with the core idle
	a_init_idle: assert property (@(posedge clk) disable iff (!arst_n)
		core_ctl.init |-> !core_busy)
		else $error("chain restart while core busy");

endmodule

// ===== tb/testbench.sv =====
// testbench for sha256_byte_stream_hasher_unit: byte messages in, digest beats out
// checks every digest word against an in-file sha-256 predictor; uses s256_pkg
module testbench
	import s256_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINISH = 1'b1;
	localparam int unsigned MAX_PRINTS = 40;

	// round constants, index 0 first
	localparam logic [0:63][31:0] ROUND_K = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct {
		logic       op;
		logic [7:0] data;
	} msg_beat_t;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_beat_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
	logic        s_axis_tuser = 1'b0;    // [0] operation
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;           // [31:0] digest_word, [34:32] word_index
	logic        m_axis_tlast;           // last_word

	// stimulus feed and expected digest words
	msg_beat_t    byte_feed_q[$];
	digest_beat_t digest_q[$];
	msg_beat_t    next_beat;

	// predictor state
	hash_t       chain;
	logic [511:0] blk_buf;
	int unsigned pend_bytes;
	logic [63:0] msg_bits;

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned beats_queued = 0;
	int unsigned beats_in = 0;
	int unsigned words_checked = 0;
	int unsigned messages_done = 0;
	int unsigned errors = 0;
	bit          in_beat_taken = 1'b0;

	sha256_byte_stream_hasher_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one 64-round compression of a big-endian 512-bit block
	function automatic hash_t sha_compress(input hash_t h, input logic [511:0] blk);
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
		hash_t nh;
		for (int i = 0; i < 16; i++)
			w[i] = blk[511 - 32 * i -: 32];
		for (int i = 16; i < 64; i++) begin
			s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		a = h[0]; b = h[1]; c = h[2]; d = h[3];
		e = h[4]; f = h[5]; g = h[6]; hh = h[7];
		for (int i = 0; i < 64; i++) begin
			t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
				+ ROUND_K[i] + w[i];
			t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			hh = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		nh[0] = h[0] + a; nh[1] = h[1] + b; nh[2] = h[2] + c; nh[3] = h[3] + d;
		nh[4] = h[4] + e; nh[5] = h[5] + f; nh[6] = h[6] + g; nh[7] = h[7] + hh;
		return nh;
	endfunction

	function automatic void put_byte(input logic [7:0] b);
		blk_buf[511 - 8 * pend_bytes -: 8] = b;
		pend_bytes++;
	endfunction

	// advance the hash state by one accepted input beat
	function automatic void hash_step(input logic op, input logic [7:0] din);
		digest_beat_t beat;
		if (op == OP_ABSORB) begin
			put_byte(din);
			msg_bits += 64'd8;
			if (pend_bytes == 64) begin
				chain = sha_compress(chain, blk_buf);
				pend_bytes = 0;
			end
		end else begin
			put_byte(PAD_BYTE);
			// no room for the length: close this block first
			if (pend_bytes > LEN_POS) begin
				while (pend_bytes < 64)
					put_byte(8'h00);
				chain = sha_compress(chain, blk_buf);
				pend_bytes = 0;
			end
			while (pend_bytes < LEN_POS)
				put_byte(8'h00);
			blk_buf[63:0] = msg_bits;
			chain = sha_compress(chain, blk_buf);
			for (int i = 0; i < 8; i++) begin
				beat.word = chain[i];
				beat.idx = 3'(i);
				beat.last = (i == 7);
				digest_q.push_back(beat);
			end
			chain = IV_HASH;
			pend_bytes = 0;
			msg_bits = '0;
			messages_done++;
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
	endtask

	task automatic push_beat(input logic op, input logic [7:0] data);
		msg_beat_t mb;
		mb.op = op;
		mb.data = data;
		byte_feed_q.push_back(mb);
		beats_queued++;
	endtask

	// a message of random bytes closed by a finish beat with random data
	task automatic push_message(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			push_beat(OP_ABSORB, 8'($urandom));
		push_beat(OP_FINISH, 8'($urandom));
	endtask

	// hold off until every queued beat is in and every digest word is out
	task automatic drain_all();
		while (beats_in != beats_queued || digest_q.size() != 0)
			@(negedge clk);
	endtask

	// input driver: new beat at the falling edge once the last one was taken
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
		if (!s_axis_tvalid || in_beat_taken) begin
			in_beat_taken = 1'b0;
			if (byte_feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_beat = byte_feed_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= next_beat.data;
				s_axis_tuser <= next_beat.op;
			end else begin
				s_axis_tvalid <= 1'b0;
				s_axis_tdata <= 8'($urandom);
				s_axis_tuser <= 1'($urandom);
			end
		end
	end

	// monitor: predict on input beats, check output beats
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (digest_q.size() == 0) begin
				report_mismatch("digest beat with none pending", 64'(m_axis_tdata), '0);
			end else begin
				if (m_axis_tdata[31:0] != digest_q[0].word)
					report_mismatch("digest_word", 64'(m_axis_tdata[31:0]),
						64'(digest_q[0].word));
				if (m_axis_tdata[34:32] != digest_q[0].idx)
					report_mismatch("word_index", 64'(m_axis_tdata[34:32]),
						64'(digest_q[0].idx));
				if (m_axis_tlast != digest_q[0].last)
					report_mismatch("last_word", 64'(m_axis_tlast), 64'(digest_q[0].last));
				if (m_axis_tdata[39:35] != 5'd0)
					report_mismatch("tdata fill bits", 64'(m_axis_tdata[39:35]), '0);
				void'(digest_q.pop_front());
				words_checked++;
			end
		end
		if (s_axis_tvalid && s_axis_tready) begin
			hash_step(s_axis_tuser, s_axis_tdata);
			beats_in++;
			in_beat_taken = 1'b1;
		end
	end

	// stimulus and end of run
	initial begin
		int unsigned edge_len [4];
		int unsigned idle_set [4];
		int unsigned stall_set [4];
		int unsigned phase_start;
		edge_len = '{55, 56, 63, 64};
		idle_set = '{0, 70, 0, 25};
		stall_set = '{0, 0, 70, 25};
		chain = IV_HASH;
		blk_buf = '0;
		pend_bytes = 0;
		msg_bits = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty messages, finish data ignored, "abc", byte extremes
		push_beat(OP_FINISH, 8'h00);
		push_beat(OP_FINISH, 8'hff);
		push_beat(OP_ABSORB, 8'h61);
		push_beat(OP_ABSORB, 8'h62);
		push_beat(OP_ABSORB, 8'h63);
		push_beat(OP_FINISH, 8'h5a);
		push_beat(OP_ABSORB, 8'h00);
		push_beat(OP_ABSORB, 8'hff);
		push_beat(OP_ABSORB, 8'h80);
		push_beat(OP_FINISH, 8'hff);
		push_beat(OP_ABSORB, 8'h55);
		push_beat(OP_ABSORB, 8'haa);
		push_beat(OP_FINISH, 8'h00);
		drain_all();

		// random messages, one pad boundary length per idling phase
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_set[p];
			stall_pct = stall_set[p];
			phase_start = beats_queued;
			push_message(edge_len[p]);
			while (beats_queued - phase_start < 95) begin
				if ($urandom_range(0, 7) == 0)
					push_message(0);
				else
					push_message($urandom_range(1, 24));
			end
			// sender holds until the hasher has emptied out
			drain_all();
		end

		repeat (200) @(negedge clk);
		if (digest_q.size() != 0)
			report_mismatch("digest words never delivered", 64'(digest_q.size()), '0);
		$display("covered %0d input beats in %0d messages, %0d digest words checked",
			beats_in, messages_done, words_checked);
		$display("empty messages, block-edge lengths 55/56/63/64, source and sink stalls");
		if (errors == 0) begin
			$display("[sha256_byte_stream_hasher_unit] OK");
		end else begin
			$display("[sha256_byte_stream_hasher_unit] ERROR");
		end
		$finish;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("timeout: %0d of %0d beats in, %0d words pending", beats_in, beats_queued,
			digest_q.size());
		$display("[sha256_byte_stream_hasher_unit] ERROR");
		$finish;
	end

endmodule
